@@ sv/sktrk_pkg.sv @@
// ----------------------------------------------------------------------------
// Scancode key tracker package
// Shared types, constants and the scancode to ASCII translation table.
// ----------------------------------------------------------------------------
package sktrk_pkg;

  // Default number of history entries.
  localparam int HISTORY_DEPTH_DEF = 49;

  // Scancode constants.
  localparam logic [7:0] PREFIX_BYTE = 8'hE0;
  localparam logic [7:0] CODE_MASK   = 8'h7F;
  localparam logic [7:0] EXT_OFFSET  = 8'h80;
  localparam int         RELEASE_BIT = 7;
  localparam int         NUM_KEYS    = 256;

  // Request kinds.
  typedef enum logic [1:0] {
    KIND_SCAN       = 2'd0,
    KIND_KEY_QUERY  = 2'd1,
    KIND_HIST_READ  = 2'd2,
    KIND_RSVD       = 2'd3
  } kind_e;

  // One input request.
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  code;
  } in_req_t;

  // One result.
  typedef struct packed {
    logic        key_down;
    logic [7:0]  char_out;
    logic        pushed;
    logic        prefix_seen;
    logic        bad_index;
  } out_rsp_t;

  // Control from the decoder to the history store.
  typedef struct packed {
    logic        push;
    logic [7:0]  push_char;
    logic        rd_en;
    logic [7:0]  rd_pos;
  } hist_ctl_t;

  // Translates a key index to ASCII; unmapped keys give zero.
  function automatic logic [7:0] ascii_lookup(input logic [7:0] idx);
    logic [7:0] ch;
    begin
      case (idx)
        8'd2:    ch = 8'd49;
        8'd3:    ch = 8'd50;
        8'd4:    ch = 8'd51;
        8'd5:    ch = 8'd52;
        8'd6:    ch = 8'd53;
        8'd7:    ch = 8'd54;
        8'd8:    ch = 8'd55;
        8'd9:    ch = 8'd56;
        8'd10:   ch = 8'd57;
        8'd11:   ch = 8'd48;
        8'd12:   ch = 8'd45;
        8'd16:   ch = 8'd113;
        8'd17:   ch = 8'd119;
        8'd18:   ch = 8'd101;
        8'd19:   ch = 8'd114;
        8'd20:   ch = 8'd116;
        8'd21:   ch = 8'd121;
        8'd22:   ch = 8'd117;
        8'd23:   ch = 8'd105;
        8'd24:   ch = 8'd111;
        8'd25:   ch = 8'd112;
        8'd30:   ch = 8'd97;
        8'd31:   ch = 8'd115;
        8'd32:   ch = 8'd100;
        8'd33:   ch = 8'd102;
        8'd34:   ch = 8'd103;
        8'd35:   ch = 8'd104;
        8'd36:   ch = 8'd106;
        8'd37:   ch = 8'd107;
        8'd38:   ch = 8'd108;
        8'd44:   ch = 8'd122;
        8'd45:   ch = 8'd120;
        8'd46:   ch = 8'd99;
        8'd47:   ch = 8'd118;
        8'd48:   ch = 8'd98;
        8'd49:   ch = 8'd110;
        8'd50:   ch = 8'd109;
        8'd51:   ch = 8'd44;
        8'd52:   ch = 8'd46;
        8'd53:   ch = 8'd47;
        8'd57:   ch = 8'd32;
        default: ch = 8'd0;
      endcase
      return ch;
    end
  endfunction

endpackage

@@ sv/sktrk_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sktrk_ram #(
  parameter int Width = 8,
  parameter int Depth = 64,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/sktrk_history.sv @@
// ----------------------------------------------------------------------------
// Keystroke history store
// Circular buffer in RAM that behaves as a shift register of pressed keys.
// ----------------------------------------------------------------------------
module sktrk_history #(
  parameter int Depth = 49
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sktrk_pkg::hist_ctl_t ctl_i,
  output logic                 rd_hit_o,
  output logic [7:0]           rd_data_o
);

  import sktrk_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [AW:0]   diff;
  logic [AW-1:0] rd_slot;

  // The head points at the most recent entry; a push advances it first.
  always_comb begin
    head_d = head_q;
    fill_d = fill_q;
    if (ctl_i.push) begin
      if (head_q == AW'(Depth - 1)) begin
        head_d = '0;
      end else begin
        head_d = head_q + AW'(1);
      end
      if (fill_q != CW'(Depth)) begin
        fill_d = fill_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      fill_q <= '0;
    end else begin
      head_q <= head_d;
      fill_q <= fill_d;
    end
  end

  // History position n lives n slots behind the head, modulo the depth.
  always_comb begin
    diff = {1'b0, head_q} - {1'b0, ctl_i.rd_pos[AW-1:0]};
    if (diff[AW]) begin
      rd_slot = diff[AW-1:0] + AW'(Depth);
    end else begin
      rd_slot = diff[AW-1:0];
    end
  end

  // Entries never pushed since reset read as zero.
  assign rd_hit_o = ctl_i.rd_pos < 8'(fill_q);

  sktrk_ram #(
    .Width (8),
    .Depth (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_i.push),
    .waddr_i (head_d),
    .wdata_i (ctl_i.push_char),
    .re_i    (ctl_i.rd_en),
    .raddr_i (rd_slot),
    .rdata_o (rd_data_o)
  );

endmodule

@@ sv/sktrk_outbuf.sv @@
// ----------------------------------------------------------------------------
// Result output register
// Holds one result toward the consumer and frees itself in the cycle it is taken.
// ----------------------------------------------------------------------------
module sktrk_outbuf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sktrk_pkg::out_rsp_t in_rsp_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sktrk_pkg::out_rsp_t out_rsp_o
);

  import sktrk_pkg::*;

  logic     valid_q;
  out_rsp_t rsp_q;

  assign in_ready_o = !valid_q || out_ready_i;

  // Valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Payload register.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      rsp_q <= in_rsp_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

@@ sv/scancode_key_tracker_unit.sv @@
// ----------------------------------------------------------------------------
// Scancode key tracker
// Decodes set-1 scancodes, tracks key state and keeps a history of presses.
// ----------------------------------------------------------------------------
// An accepted request passes through the stage-one register and then the output
// register before its result is valid; a stall at the output can come between.
// Throughput: one request per cycle unless the output side stalls; the key map and
// history update at accept. Key queries and history reads use registered RAM ports,
// read at accept. Reset clears the extended flag and the history fill count at once,
// then a clearing pass zeroes all 256 key map entries while in_ready_o stays low.
module scancode_key_tracker_unit #(
  parameter int HistoryDepth = sktrk_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sktrk_pkg::in_req_t  in_req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sktrk_pkg::out_rsp_t out_rsp_o
);

  import sktrk_pkg::*;

  logic                accept;
  logic                ext_q, ext_d;
  logic [7:0]          key_idx;
  logic                km_we;
  logic                km_wdata;
  logic                km_re;
  logic                km_ram_we;
  logic [7:0]          km_ram_waddr;
  logic                km_ram_wdata;
  logic                key_rdata;
  logic                clr_busy_q;
  logic [7:0]          clr_addr_q;
  hist_ctl_t           hist_ctl;
  logic                hist_hit;
  logic [7:0]          hist_rdata;
  out_rsp_t            rsp;
  logic                s1_valid_q;
  out_rsp_t            s1_rsp_q;
  logic                s1_hit_q;
  logic                s1_key_q;
  out_rsp_t            s1_out;
  logic                ob_ready;

  assign accept = in_valid_i && in_ready_o;

  // Key index: low seven code bits, offset into the upper half when extended.
  assign key_idx = (in_req_i.code & CODE_MASK) | (ext_q ? EXT_OFFSET : 8'h00);

  // Request decoder: next state and stage-one result.
  always_comb begin
    ext_d              = ext_q;
    km_we              = 1'b0;
    km_wdata           = 1'b0;
    km_re              = 1'b0;
    rsp                = '0;
    hist_ctl           = '0;
    hist_ctl.push_char = ascii_lookup(key_idx);
    hist_ctl.rd_pos    = in_req_i.code;
    unique case (in_req_i.kind)
      KIND_SCAN: begin
        if (in_req_i.code == PREFIX_BYTE) begin
          ext_d           = 1'b1;
          rsp.prefix_seen = 1'b1;
        end else begin
          ext_d    = 1'b0;
          km_we    = accept;
          km_wdata = !in_req_i.code[RELEASE_BIT];
          if (!in_req_i.code[RELEASE_BIT]) begin
            rsp.key_down  = 1'b1;
            rsp.pushed    = 1'b1;
            rsp.char_out  = hist_ctl.push_char;
            hist_ctl.push = accept;
          end
        end
      end
      KIND_KEY_QUERY: begin
        km_re = accept;
      end
      KIND_HIST_READ: begin
        rsp.bad_index  = in_req_i.code >= 8'(HistoryDepth);
        hist_ctl.rd_en = accept;
      end
      default: begin
      end
    endcase
  end

  // Extended flag commits on each accepted request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_q <= 1'b0;
    end else if (accept) begin
      ext_q <= ext_d;
    end
  end

  // Clearing pass over the key map after reset, one entry per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 8'd1;
      if (clr_addr_q == 8'(NUM_KEYS - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // Key map write port is owned by the clearing pass until it finishes.
  assign km_ram_we    = clr_busy_q || km_we;
  assign km_ram_waddr = clr_busy_q ? clr_addr_q : key_idx;
  assign km_ram_wdata = !clr_busy_q && km_wdata;

  sktrk_ram #(
    .Width (1),
    .Depth (NUM_KEYS)
  ) u_key_map (
    .clk_i   (clk_i),
    .we_i    (km_ram_we),
    .waddr_i (km_ram_waddr),
    .wdata_i (km_ram_wdata),
    .re_i    (km_re),
    .raddr_i (in_req_i.code),
    .rdata_o (key_rdata)
  );

  sktrk_history #(
    .Depth (HistoryDepth)
  ) u_history (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (hist_ctl),
    .rd_hit_o  (hist_hit),
    .rd_data_o (hist_rdata)
  );

  // Stage one waits for the RAM read data alongside the decoded result.
  assign in_ready_o = !clr_busy_q && (!s1_valid_q || ob_ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_rsp_q <= rsp;
      s1_hit_q <= (in_req_i.kind == KIND_HIST_READ) && !rsp.bad_index && hist_hit;
      s1_key_q <= (in_req_i.kind == KIND_KEY_QUERY);
    end
  end

  // Merge the history entry or the queried key state into the result.
  always_comb begin
    s1_out = s1_rsp_q;
    if (s1_hit_q) begin
      s1_out.char_out = hist_rdata;
    end
    if (s1_key_q) begin
      s1_out.key_down = key_rdata;
    end
  end

  sktrk_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_valid_q),
    .in_ready_o  (ob_ready),
    .in_rsp_i    (s1_out),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  // An out-of-range history read never carries a character or a push.
  a_bad_index_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.bad_index |->
      out_rsp_o.char_out == 8'h00 && !out_rsp_o.pushed)
    else $error("bad_index result carries data");

  // Push, prefix and bad index are mutually exclusive.
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      $countones({out_rsp_o.pushed, out_rsp_o.prefix_seen, out_rsp_o.bad_index}) <= 1)
    else $error("conflicting result flags");

  // A push always reports the key as down.
  a_push_key_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.pushed |-> out_rsp_o.key_down)
    else $error("push without key down");

  // An accepted prefix byte leaves the extended flag set.
  a_prefix_sets_ext: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_req_i.kind == KIND_SCAN && in_req_i.code == PREFIX_BYTE |=> ext_q)
    else $error("prefix did not set extended flag");

endmodule

@@ tb/scancode_key_tracker_unit_tb.sv @@
// ----------------------------------------------------------------------------
// Scancode key tracker testbench
// Drives a directed table of requests and then random keystroke streams
// through the tracker. Both handshake sides idle at random. Every result is
// checked field by field against its fixed table result or a local model of the key
// map, the extended prefix and the press history.
// ----------------------------------------------------------------------------
module scancode_key_tracker_unit_tb;
  import sktrk_pkg::*;

  localparam int HIST_DEPTH     = HISTORY_DEPTH_DEF;
  localparam int RANDOM_ITEMS   = 1025;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ASCII_SPAN     = 60;
  localparam int MAX_HELD       = 16;

  // ASCII for the low key indexes; every index above the span is unmapped.
  localparam logic [0:ASCII_SPAN-1][7:0] SCAN_ASCII = {
    8'd0,   8'd0,   8'd49,  8'd50,  8'd51,  8'd52,  8'd53,  8'd54,  8'd55,  8'd56,
    8'd57,  8'd48,  8'd45,  8'd0,   8'd0,   8'd0,   8'd113, 8'd119, 8'd101, 8'd114,
    8'd116, 8'd121, 8'd117, 8'd105, 8'd111, 8'd112, 8'd0,   8'd0,   8'd0,   8'd0,
    8'd97,  8'd115, 8'd100, 8'd102, 8'd103, 8'd104, 8'd106, 8'd107, 8'd108, 8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd122, 8'd120, 8'd99,  8'd118, 8'd98,  8'd110,
    8'd109, 8'd44,  8'd46,  8'd47,  8'd0,   8'd0,   8'd0,   8'd32,  8'd0,   8'd0
  };

  // Results that can be read straight off the request.
  localparam out_rsp_t NO_RSP = '0;
  localparam out_rsp_t PREFIX_RSP = '{key_down: 1'b0, char_out: 8'd0, pushed: 1'b0,
                                      prefix_seen: 1'b1, bad_index: 1'b0};
  localparam out_rsp_t BAD_POS_RSP = '{key_down: 1'b0, char_out: 8'd0, pushed: 1'b0,
                                       prefix_seen: 1'b0, bad_index: 1'b1};

  typedef struct packed {
    kind_e      kind;
    logic [7:0] code;
    logic       has_rsp;
    out_rsp_t   rsp;
  } plan_row_t;

  // Directed requests; rows without a fixed result use the local model.
  plan_row_t directed_plan [25] = '{
    '{KIND_KEY_QUERY, 8'h00, 1'b1, NO_RSP},
    '{KIND_KEY_QUERY, 8'hFF, 1'b1, NO_RSP},
    '{KIND_HIST_READ, 8'd0,  1'b1, NO_RSP},
    '{KIND_HIST_READ, 8'd48, 1'b1, NO_RSP},
    '{KIND_HIST_READ, 8'd49, 1'b1, BAD_POS_RSP},
    '{KIND_HIST_READ, 8'hFF, 1'b1, BAD_POS_RSP},
    '{KIND_RSVD,      8'hFF, 1'b1, NO_RSP},
    '{KIND_SCAN,      8'hE0, 1'b1, PREFIX_RSP},
    '{KIND_SCAN,      8'hE0, 1'b1, PREFIX_RSP},
    '{KIND_KEY_QUERY, 8'h1C, 1'b0, NO_RSP},
    '{KIND_SCAN,      8'h1C, 1'b0, NO_RSP},
    '{KIND_KEY_QUERY, 8'h9C, 1'b0, NO_RSP},
    '{KIND_SCAN,      8'h1E, 1'b0, NO_RSP},
    '{KIND_HIST_READ, 8'd0,  1'b0, NO_RSP},
    '{KIND_HIST_READ, 8'd1,  1'b0, NO_RSP},
    '{KIND_SCAN,      8'h9E, 1'b0, NO_RSP},
    '{KIND_KEY_QUERY, 8'h1E, 1'b0, NO_RSP},
    '{KIND_SCAN,      8'hE0, 1'b1, PREFIX_RSP},
    '{KIND_SCAN,      8'h9C, 1'b0, NO_RSP},
    '{KIND_KEY_QUERY, 8'h9C, 1'b0, NO_RSP},
    '{KIND_SCAN,      8'h00, 1'b0, NO_RSP},
    '{KIND_SCAN,      8'h7F, 1'b0, NO_RSP},
    '{KIND_SCAN,      8'hE0, 1'b1, PREFIX_RSP},
    '{KIND_SCAN,      8'h7F, 1'b0, NO_RSP},
    '{KIND_KEY_QUERY, 8'hFF, 1'b0, NO_RSP}
  };

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  in_req_t  in_req_i;
  logic     out_valid_o;
  logic     out_ready_i;
  out_rsp_t out_rsp_o;

  // Local copy of the tracker state.
  logic       ext_pending;
  logic       key_held [NUM_KEYS];
  logic [7:0] press_log [HIST_DEPTH];

  out_rsp_t   awaited_results [$];
  logic [6:0] held_codes [$];
  int         mismatches = 0;
  int         idle_cycles = 0;
  bit         steady_phase = 1'b0;

  scancode_key_tracker_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  always #1 clk_i = ~clk_i;

  // Applies one request to the local state and returns its result.
  function automatic out_rsp_t track_request(in_req_t req);
    out_rsp_t   rsp;
    logic [7:0] key_idx;
    rsp = '0;
    case (req.kind)
      KIND_SCAN: begin
        if (req.code == PREFIX_BYTE) begin
          ext_pending     = 1'b1;
          rsp.prefix_seen = 1'b1;
        end else begin
          key_idx = (req.code & CODE_MASK) + (ext_pending ? EXT_OFFSET : 8'd0);
          if (!req.code[RELEASE_BIT]) begin
            key_held[key_idx] = 1'b1;
            rsp.char_out = (key_idx < ASCII_SPAN) ? SCAN_ASCII[key_idx] : 8'd0;
            for (int i = HIST_DEPTH - 1; i > 0; i--) press_log[i] = press_log[i-1];
            press_log[0] = rsp.char_out;
            rsp.key_down = 1'b1;
            rsp.pushed   = 1'b1;
          end else begin
            key_held[key_idx] = 1'b0;
          end
          ext_pending = 1'b0;
        end
      end
      KIND_KEY_QUERY: rsp.key_down = key_held[req.code];
      KIND_HIST_READ: begin
        if (req.code >= HIST_DEPTH) rsp.bad_index = 1'b1;
        else rsp.char_out = press_log[req.code];
      end
      default: ;
    endcase
    return rsp;
  endfunction

  // Idle length for either side: mostly none, sometimes short, rarely long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady_phase || roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Random request shaped like typing: presses, matching releases, prefixes,
  // queries of held keys and history reads, with some noise mixed in.
  function automatic in_req_t next_keystroke();
    in_req_t    req;
    int         roll;
    int         pick;
    logic [6:0] raw;
    roll     = $urandom_range(0, 99);
    req.kind = KIND_SCAN;
    req.code = 8'($urandom);
    if (roll < 50) begin
      if (roll < 7) begin
        req.code = PREFIX_BYTE;
      end else if (roll < 10) begin
        // Arbitrary byte, already drawn.
      end else if (roll < 28 && held_codes.size() != 0) begin
        pick = $urandom_range(0, held_codes.size() - 1);
        raw  = held_codes[pick];
        held_codes.delete(pick);
        req.code = {1'b1, raw};
      end else begin
        raw = ($urandom_range(0, 3) != 0) ? 7'($urandom_range(1, 8'h39)) : 7'($urandom);
        req.code = {1'b0, raw};
        if (held_codes.size() < MAX_HELD) held_codes.push_back(raw);
      end
    end else if (roll < 70) begin
      req.kind = KIND_KEY_QUERY;
      if (roll < 60 && held_codes.size() != 0) begin
        req.code = {1'($urandom), held_codes[$urandom_range(0, held_codes.size() - 1)]};
      end
    end else if (roll < 95) begin
      req.kind = KIND_HIST_READ;
      if (roll < 91) req.code = 8'($urandom_range(0, HIST_DEPTH - 1));
    end else begin
      req.kind = KIND_RSVD;
    end
    return req;
  endfunction

  // Presents one request, starting and ending at a falling edge.
  task automatic send_req(in_req_t req, logic has_rsp, out_rsp_t fixed_rsp);
    int       gap;
    out_rsp_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = track_request(req);
    awaited_results.push_back(has_rsp ? fixed_rsp : predicted);
    @(negedge clk_i);
  endtask

  // Holds off the sender until every outstanding result has come back.
  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (awaited_results.size() != 0);
  endtask

  task automatic flag_mismatch(string what, out_rsp_t want, out_rsp_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected kd=%0b ch=%0d push=%0b pfx=%0b bad=%0b, got kd=%0b ch=%0d push=%0b pfx=%0b bad=%0b",
               $time, what, want.key_down, want.char_out, want.pushed, want.prefix_seen,
               want.bad_index, got.key_down, got.char_out, got.pushed, got.prefix_seen,
               got.bad_index);
    end
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_results.size() == 0) begin
        flag_mismatch("result with no request pending", NO_RSP, out_rsp_o);
      end else begin
        if (out_rsp_o.key_down !== awaited_results[0].key_down ||
            out_rsp_o.char_out !== awaited_results[0].char_out ||
            out_rsp_o.pushed !== awaited_results[0].pushed ||
            out_rsp_o.prefix_seen !== awaited_results[0].prefix_seen ||
            out_rsp_o.bad_index !== awaited_results[0].bad_index) begin
          flag_mismatch("result mismatch", awaited_results[0], out_rsp_o);
        end
        void'(awaited_results.pop_front());
      end
    end
  end

  // Watchdog on cycles where neither side moves a request.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: ready bursts broken by stalls of random length.
  initial begin
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
  end

  // Request side: reset, directed table, random typing, drain.
  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    ext_pending = 1'b0;
    foreach (key_held[i]) key_held[i] = 1'b0;
    foreach (press_log[i]) press_log[i] = 8'd0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_plan[i]) begin
      send_req('{kind: directed_plan[i].kind, code: directed_plan[i].code},
               directed_plan[i].has_rsp, directed_plan[i].rsp);
    end
    hold_until_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // One stretch with no idling on either side.
      steady_phase = (n >= 300 && n < 400);
      if (n == RANDOM_ITEMS / 2) hold_until_drained();
      send_req(next_keystroke(), 1'b0, NO_RSP);
    end
    steady_phase = 1'b0;
    in_valid_i <= 1'b0;

    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    mismatches += awaited_results.size();
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
